// File: rtl/core/substring_first_match_finder_top_macros.svh
// assertion macros for the substring finder checker
// no dependencies; included by the checker file only
`ifndef SUBSTRING_FIRST_MATCH_FINDER_TOP_MACROS_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_TOP_MACROS_SVH

// clocked assertion, switched off while reset is high
`define SFMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SFMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sfmf_pkg.sv
// shared types and constants of the substring first-match finder
// no dependencies; used by every module of the block
package sfmf_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 4;
   localparam int INDEX_W    = 16;
   localparam int CFG_W      = 64;
   localparam int PAT_SLOTS  = CFG_W / BYTE_W;
   localparam int SLOT_W     = $clog2(PAT_SLOTS);
   localparam int INDEX_SPAN = 65536;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 1'd1;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
   } result_type;

endpackage

// File: rtl/core/substring_first_match_finder_top.sv
// result: registered in the output buffer (main or skid register) from the transfer that causes it
// throughput: one haystack byte per cycle; the cell chain compares all needle
//    bytes in the cycle of the transfer, req_tready drops only with two results held or in reset
// reset: synchronous; clears needle registers, window cells, position and buffers
// depends on sfmf_pkg, sfmf_cell, sfmf_out_buf
module substring_first_match_finder_top #(
   parameter int PATTERN_MAX = 8,
   parameter int MAX_LEN     = 65536
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfmf_pkg::BYTE_W-1:0]        req_tdata,   // data_byte
   input  logic                               req_tuser,   // has_byte
   input  logic                               req_tlast,   // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfmf_pkg::INDEX_W-1:0]       rsp_tdata,   // match_index
   output logic                               rsp_tuser,   // found
   input  logic                               csr_we,
   input  logic [sfmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfmf_pkg::CFG_W-1:0]         csr_wdata
);
   import sfmf_pkg::*;

   localparam int LIMIT  = (MAX_LEN > INDEX_SPAN) ? INDEX_SPAN : MAX_LEN;
   localparam int POS_W  = $clog2(LIMIT + 1);
   localparam int WIDE_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;

   logic [CFG_W-1:0]       pattern_bytes_ff;
   logic [CFG_W-1:0]       pattern_bytes_in;
   logic [LEN_W-1:0]       pattern_length_ff;
   logic [LEN_W-1:0]       pattern_length_in;
   logic [POS_W-1:0]       pos_ff;
   logic [POS_W-1:0]       pos_in;
   logic                   reported_ff;
   logic                   reported_in;

   logic [LEN_W-1:0]       needle_len;
   logic                   accept;
   logic                   buf_ready;
   logic                   shift;
   logic [POS_W-1:0]       pos_step;
   logic                   len_zero;
   logic                   empty_hit;
   logic                   cmp_hit;
   logic                   end_miss;
   logic [WIDE_W-1:0]      diff_wide;
   logic                   res_valid;
   result_type             res;
   result_type             rsp_data;
   cell_ctl_type           ctl;
   logic [BYTE_W-1:0]      cell_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_hit;

   assign req_tready = buf_ready && !reset;
   assign accept     = req_tvalid && req_tready;

   assign needle_len = (pattern_length_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                                 : pattern_length_ff;
   assign len_zero   = (needle_len == '0);
   assign shift      = accept && req_tuser && (pos_ff < POS_W'(LIMIT));
   assign pos_step   = pos_ff + POS_W'(1);
   assign diff_wide  = WIDE_W'(pos_step) - WIDE_W'(needle_len);

   assign empty_hit  = accept && !reported_ff && len_zero;
   assign cmp_hit    = shift && !reported_ff && !len_zero
                       && (pos_step >= POS_W'(needle_len)) && (&cell_hit);
   assign end_miss   = accept && req_tlast && !reported_ff && !empty_hit && !cmp_hit;
   assign res_valid  = empty_hit || cmp_hit || end_miss;

   assign res.found       = empty_hit || cmp_hit;
   assign res.match_index = cmp_hit ? diff_wide[INDEX_W-1:0] : '0;

   assign ctl.shift = shift;
   assign ctl.clear = accept && req_tlast;

   generate
      for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
         logic [BYTE_W-1:0] prev;
         if (k == 0) begin : g_head
            assign prev = req_tdata;
         end else begin : g_body
            assign prev = cell_byte[k-1];
         end
         sfmf_cell #(
            .CELL_IDX (k)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctl           (ctl),
            .byte_prev     (prev),
            .pattern_bytes (pattern_bytes_ff),
            .needle_len    (needle_len),
            .byte_out      (cell_byte[k]),
            .hit           (cell_hit[k])
         );
      end
   endgenerate

   always_comb begin
      pattern_bytes_in  = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_BYTES: begin
               pattern_bytes_in = csr_wdata;
            end
            CSR_PATTERN_LENGTH: begin
               pattern_length_in = csr_wdata[LEN_W-1:0];
            end
            default: begin
               pattern_bytes_in = pattern_bytes_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (ctl.clear) begin
         pos_in      = '0;
         reported_in = 1'b0;
      end else begin
         pos_in      = shift ? pos_step : pos_ff;
         reported_in = reported_ff || empty_hit || cmp_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
         pos_ff            <= '0;
         reported_ff       <= 1'b0;
      end else begin
         pattern_bytes_ff  <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
         pos_ff            <= pos_in;
         reported_ff       <= reported_in;
      end
   end

   sfmf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (buf_ready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data.match_index;
   assign rsp_tuser = rsp_data.found;

endmodule

// File: rtl/core/sfmf_cell.sv
// one window cell: holds one haystack byte and compares the incoming byte
// against its needle byte; depends on sfmf_pkg
module sfmf_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sfmf_pkg::cell_ctl_type          ctl,
   input  logic [sfmf_pkg::BYTE_W-1:0]     byte_prev,
   input  logic [sfmf_pkg::CFG_W-1:0]      pattern_bytes,
   input  logic [sfmf_pkg::LEN_W-1:0]      needle_len,
   output logic [sfmf_pkg::BYTE_W-1:0]     byte_out,
   output logic                            hit
);
   import sfmf_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic              active;
   logic [LEN_W-1:0]  slot_wide;
   logic [SLOT_W-1:0] slot;
   logic [BYTE_W-1:0] want;

   // cell k compares against needle byte len-1-k
   assign active    = LEN_W'(CELL_IDX) < needle_len;
   assign slot_wide = needle_len - LEN_W'(CELL_IDX) - LEN_W'(1);
   assign slot      = slot_wide[SLOT_W-1:0];
   assign want      = pattern_bytes[slot*BYTE_W +: BYTE_W];
   assign hit       = !active || (byte_prev == want);
   assign byte_out  = byte_ff;

   always_comb begin
      if (ctl.clear) begin
         byte_in = '0;
      end else if (ctl.shift) begin
         byte_in = byte_prev;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

endmodule

// File: rtl/core/sfmf_out_buf.sv
// result register with skid stage between finder and result stream
// depends on sfmf_pkg
module sfmf_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  sfmf_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sfmf_pkg::result_type out_data
);
   import sfmf_pkg::*;

   logic       main_valid_ff;
   logic       main_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type main_data_ff;
   result_type main_data_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (main_valid_ff && !out_ready) begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: rtl/core/sfmf_checker.sv
// port-level checks on the substring finder's result stream
// depends on sfmf_pkg and the assertion macro header; bound to the top level
`include "substring_first_match_finder_top_macros.svh"

module sfmf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sfmf_pkg::INDEX_W-1:0]  rsp_tdata,
   input logic                          rsp_tuser
);
   import sfmf_pkg::*;

   `SFMF_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_tvalid, "result after reset")
   `SFMF_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `SFMF_ASSERT(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "not-found with index")
   `SFMF_ASSERT(a_stall_cause, clock, reset, !req_tready |-> rsp_tvalid, "input stalled with no result held")

endmodule

bind substring_first_match_finder_top sfmf_checker u_sfmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: bench/tb_top.sv
// self-checking bench for substring_first_match_finder_top: needle registers,
// haystack byte stream and first-match results, checked against an in-bench model
// depends on sfmf_pkg and the rtl of the finder
`timescale 1ns / 100ps

module tb_top;
   import sfmf_pkg::*;

   localparam int PATTERN_MAX  = 8;
   localparam int MAX_LEN      = 65536;
   localparam int LEN_LIMIT    = (MAX_LEN > INDEX_SPAN) ? INDEX_SPAN : MAX_LEN;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_ITEMS   = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              has;
      logic              last;
   } hay_item_type;

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] csr_sel;
      logic [CFG_W-1:0]     csr_val;
      hay_item_type         item;
      bit                   typed;
      bit                   want_hit;
      result_type           want;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata;   // data_byte
   logic                 req_tuser;   // has_byte
   logic                 req_tlast;   // last_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [INDEX_W-1:0]   rsp_tdata;   // match_index
   logic                 rsp_tuser;   // found
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // model state
   logic [CFG_W-1:0]  needle_bytes;
   logic [LEN_W-1:0]  needle_len;
   logic [BYTE_W-1:0] hay_window [PATTERN_MAX];
   int                hay_pos;
   bit                match_reported;

   result_type     hit_queue [$];
   hay_item_type   hay_queue [$];
   script_row_type script [$];
   result_type     head_hit;

   bit req_idling;
   bit rsp_idling;
   bit hold_request;
   int hold_left;
   int stall_left;
   int quiet_cycles;
   int fail_count;
   int results_checked;
   int items_sent;
   int cfg_writes;

   substring_first_match_finder_top #(
      .PATTERN_MAX(PATTERN_MAX),
      .MAX_LEN    (MAX_LEN)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_string();
      hay_window = '{default: '0};
      hay_pos = 0;
      match_reported = 1'b0;
   endtask

   // advances the model by one haystack item and gives the result it causes, if any
   task automatic scan_byte(input hay_item_type it, output bit hit, output result_type res);
      int nl;
      bit ok;
      nl = (needle_len > PATTERN_MAX) ? PATTERN_MAX : needle_len;
      hit = 1'b0;
      res = '0;
      if (!match_reported && nl == 0) begin
         hit = 1'b1;
         res.found = 1'b1;
         match_reported = 1'b1;
      end
      if (it.has && hay_pos < LEN_LIMIT) begin
         for (int k = PATTERN_MAX - 1; k > 0; k--) hay_window[k] = hay_window[k-1];
         hay_window[0] = it.data;
         hay_pos++;
         if (!match_reported && nl > 0 && hay_pos >= nl) begin
            ok = 1'b1;
            for (int k = 0; k < nl; k++)
               if (hay_window[nl-1-k] != needle_bytes[8*k +: 8]) ok = 1'b0;
            if (ok) begin
               hit = 1'b1;
               res.found = 1'b1;
               res.match_index = 16'(hay_pos - nl);
               match_reported = 1'b1;
            end
         end
      end
      if (it.last) begin
         if (!match_reported) begin
            hit = 1'b1;
            res = '0;
         end
         clear_string();
      end
   endtask

   function automatic script_row_type csr_row(input logic [CSR_IDX_W-1:0] sel,
                                              input logic [CFG_W-1:0] v);
      script_row_type r;
      r.is_csr = 1'b1;
      r.csr_sel = sel;
      r.csr_val = v;
      r.item = '0;
      r.typed = 1'b0;
      r.want_hit = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic script_row_type byte_row(input logic [BYTE_W-1:0] d, input bit h,
                                               input bit l);
      script_row_type r;
      r.is_csr = 1'b0;
      r.csr_sel = '0;
      r.csr_val = '0;
      r.item = '{data: d, has: h, last: l};
      r.typed = 1'b0;
      r.want_hit = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic script_row_type typed_row(input logic [BYTE_W-1:0] d, input bit h,
                                                input bit l, input bit hit, input bit fnd,
                                                input logic [INDEX_W-1:0] idx);
      script_row_type r;
      r = byte_row(d, h, l);
      r.typed = 1'b1;
      r.want_hit = hit;
      r.want.found = fnd;
      r.want.match_index = idx;
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input hay_item_type it, input bit typed, input bit want_hit,
                            input result_type want);
      bit hit;
      result_type res;
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.data;
      req_tuser  <= it.has;
      req_tlast  <= it.last;
      do @(posedge clock); while (!req_tready);
      scan_byte(it, hit, res);
      if (typed) begin
         hit = want_hit;
         res = want;
      end
      if (hit) hit_queue.push_back(res);
      items_sent++;
      @(negedge clock);
   endtask

   // waits until the finder is idle, then writes one register
   task automatic write_csr(input logic [CSR_IDX_W-1:0] sel, input logic [CFG_W-1:0] v);
      req_tvalid <= 1'b0;
      while (hit_queue.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_PATTERN_BYTES) needle_bytes = v;
      else needle_len = v[LEN_W-1:0];
      cfg_writes++;
   endtask

   // one haystack string, mostly built from needle bytes, often with the needle planted
   task automatic make_string();
      int nl;
      int len;
      int at;
      int sl;
      bit tail_empty;
      logic [BYTE_W-1:0] s [$];
      nl = (needle_len > PATTERN_MAX) ? PATTERN_MAX : needle_len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(0, 20);
      tail_empty = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
         if (nl > 0 && $urandom_range(0, 9) < 6) begin
            sl = $urandom_range(0, nl - 1);
            s.push_back(needle_bytes[8*sl +: 8]);
         end else begin
            s.push_back(BYTE_W'($urandom));
         end
      end
      if (nl > 0 && len >= nl && $urandom_range(0, 9) < 6) begin
         at = $urandom_range(0, len - nl);
         for (int k = 0; k < nl; k++) s[at+k] = needle_bytes[8*k +: 8];
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 14) == 0)
            hay_queue.push_back('{data: BYTE_W'($urandom), has: 1'b0, last: 1'b0});
         hay_queue.push_back('{data: s[i], has: 1'b1, last: (i == len - 1) && !tail_empty});
      end
      if (len == 0 || tail_empty)
         hay_queue.push_back('{data: BYTE_W'($urandom), has: 1'b0, last: 1'b1});
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_queue.size() == 0) begin
            $error("result with none expected: found %0b index %0d", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            head_hit = hit_queue.pop_front();
            results_checked++;
            if (rsp_tuser !== head_hit.found) begin
               $error("found: expected %0b, got %0b", head_hit.found, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata !== head_hit.match_index) begin
               $error("match_index: expected %0d, got %0d", head_hit.match_index, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("substring_first_match_finder_top: mismatch");
         $finish;
      end
   end

   initial begin
      int budget;
      int random_sent;
      int nl;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      needle_bytes = '0;
      needle_len = '0;
      clear_string();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      random_sent = 0;

      // empty needle after reset, then eight 0xff bytes with an over-long length
      script.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0));
      script.push_back(typed_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
      script.push_back(typed_row(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0));
      script.push_back(csr_row(CSR_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
      script.push_back(csr_row(CSR_PATTERN_LENGTH, 64'hF));
      repeat (7) script.push_back(typed_row(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0));
      script.push_back(typed_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 16'd0));
      script.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0));
      // partial match, byte-less item inside the string, then a full match
      script.push_back(csr_row(CSR_PATTERN_BYTES, 64'hFFFF_FFFF_FF00_8000));
      script.push_back(csr_row(CSR_PATTERN_LENGTH, 64'h3));
      script.push_back(byte_row(8'h00, 1'b1, 1'b0));
      script.push_back(byte_row(8'h80, 1'b1, 1'b0));
      script.push_back(byte_row(8'h01, 1'b1, 1'b0));
      script.push_back(byte_row(8'h80, 1'b0, 1'b0));
      script.push_back(byte_row(8'h00, 1'b1, 1'b0));
      script.push_back(byte_row(8'h80, 1'b1, 1'b0));
      script.push_back(byte_row(8'h00, 1'b1, 1'b0));
      script.push_back(byte_row(8'h00, 1'b1, 1'b1));
      // needle changed in the middle of a string
      script.push_back(byte_row(8'h7F, 1'b1, 1'b0));
      script.push_back(csr_row(CSR_PATTERN_BYTES, 64'h7F));
      script.push_back(csr_row(CSR_PATTERN_LENGTH, 64'h1));
      script.push_back(byte_row(8'h7F, 1'b1, 1'b1));
      script.push_back(typed_row(8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0));
      script.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr)
            write_csr(script[i].csr_sel, script[i].csr_val);
         else
            send_item(script[i].item, script[i].typed, script[i].want_hit, script[i].want);
      end

      // receiver held off while single-item strings keep coming
      write_csr(CSR_PATTERN_BYTES, '0);
      write_csr(CSR_PATTERN_LENGTH, '0);
      hold_request = 1'b1;
      repeat (24)
         send_item('{data: BYTE_W'($urandom), has: 1'($urandom), last: 1'b1}, 1'b0, 1'b0, '0);

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end else begin
            req_idling = ($urandom_range(0, 3) != 0);
            rsp_idling = ($urandom_range(0, 3) != 0);
         end
         case ($urandom_range(0, 9))
            0: nl = 0;
            1: nl = $urandom_range(9, 15);
            default: nl = $urandom_range(1, 8);
         endcase
         write_csr(CSR_PATTERN_BYTES, {32'($urandom), 32'($urandom)});
         write_csr(CSR_PATTERN_LENGTH, {28'($urandom), 32'($urandom), 4'(nl)});
         budget = $urandom_range(40, 120);
         repeat (budget) begin
            if (hay_queue.size() == 0) make_string();
            send_item(hay_queue.pop_front(), 1'b0, 1'b0, '0);
            random_sent++;
         end
      end
      while (hay_queue.size() != 0) send_item(hay_queue.pop_front(), 1'b0, 1'b0, '0);
      req_tvalid <= 1'b0;

      while (hit_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      fail_count += hit_queue.size();

      $display("%0d results checked from %0d haystack items, %0d register writes",
               results_checked, items_sent, cfg_writes);
      $display("empty and over-long needles, mid-string needle change, long output stall");
      if (fail_count == 0)
         $display("substring_first_match_finder_top: match");
      else
         $display("substring_first_match_finder_top: mismatch");
      $finish;
   end

endmodule

// File: substring_first_match_finder_top.f
+incdir+rtl/core
rtl/core/sfmf_pkg.sv
rtl/core/sfmf_cell.sv
rtl/core/sfmf_out_buf.sv
rtl/core/substring_first_match_finder_top.sv
rtl/core/sfmf_checker.sv
bench/tb_top.sv
